@@ hw/rtl/nse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nse_pkg
// Shared types and constants of the NAND sector ECC engine.
// ----------------------------------------------------------------------------
package nse_pkg;

  localparam int unsigned IDX_W     = 9;
  localparam int unsigned NUM_PAIRS = 9;
  localparam int unsigned NUM_COLS  = 2 * NUM_PAIRS;
  localparam int unsigned PAR_W     = 12;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  localparam logic [1:0] SECTOR_CLEAN = 2'd0;
  localparam logic [1:0] SECTOR_ECC   = 2'd1;
  localparam logic [1:0] SECTOR_FIX   = 2'd2;
  localparam logic [1:0] SECTOR_UNCOR = 2'd3;

  localparam logic [1:0] PAGE_CLEAN     = 2'd0;
  localparam logic [1:0] PAGE_CORRECTED = 2'd1;
  localparam logic [1:0] PAGE_UNCOR     = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX  = 9'h1ff;
  localparam logic [PAR_W-1:0] ALL_PAR   = 12'hfff;
  localparam logic [31:0]      ERASED    = 32'hffff_ffff;

  localparam logic [7:0] MASK_E0 = 8'h55;
  localparam logic [7:0] MASK_O0 = 8'haa;
  localparam logic [7:0] MASK_E1 = 8'h33;
  localparam logic [7:0] MASK_O1 = 8'hcc;
  localparam logic [7:0] MASK_E2 = 8'h0f;
  localparam logic [7:0] MASK_O2 = 8'hf0;

  typedef struct packed {
    logic [1:0]       sector_status;
    logic [IDX_W-1:0] fix_byte;
    logic [2:0]       fix_bit;
    logic [1:0]       page_status;
  } chk_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/nse_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nse_item_if
// Input channel: one beat is a data byte or a check against a stored code.
// ----------------------------------------------------------------------------
interface nse_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic [31:0] stored_ecc;
  logic        last_sector;

  modport source (output valid, cmd, data_byte, stored_ecc, last_sector, input ready);
  modport sink   (input valid, cmd, data_byte, stored_ecc, last_sector, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nse_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nse_result_if
// Result channel: one beat is a computed code or a check verdict.
// ----------------------------------------------------------------------------
interface nse_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] ecc_value;
  logic [1:0]  sector_status;
  logic [8:0]  fix_byte;
  logic [2:0]  fix_bit;
  logic [1:0]  page_status;
  logic        page_done;

  modport source (output valid, result_kind, ecc_value, sector_status, fix_byte, fix_bit,
                  page_status, page_done, input ready);
  modport sink   (input valid, result_kind, ecc_value, sector_status, fix_byte, fix_bit,
                  page_status, page_done, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nse_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nse_accum
// Column XOR accumulator and code generator over one 512-byte sector.
// ----------------------------------------------------------------------------
module nse_accum (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [7:0]  data_byte,
  output logic             code_done,
  output logic [31:0]      code_value,
  output logic [31:0]      held_code
);

  logic [7:0]                  col      [nse_pkg::NUM_COLS];
  logic [7:0]                  col_next [nse_pkg::NUM_COLS];
  logic [nse_pkg::IDX_W-1:0]   byte_count;
  logic [7:0]                  all_xor;
  logic [nse_pkg::PAR_W-1:0]   ev;
  logic [nse_pkg::PAR_W-1:0]   od;

  assign code_done = (byte_count == nse_pkg::LAST_IDX);

  always_comb begin
    for (int j = 0; j < nse_pkg::NUM_PAIRS; j++) begin
      col_next[2*j]   = byte_count[j] ? col[2*j] : (col[2*j] ^ data_byte);
      col_next[2*j+1] = byte_count[j] ? (col[2*j+1] ^ data_byte) : col[2*j+1];
    end
  end

  always_comb begin
    all_xor = col_next[0] ^ col_next[1];
    ev[0] = ^(all_xor & nse_pkg::MASK_E0);
    od[0] = ^(all_xor & nse_pkg::MASK_O0);
    ev[1] = ^(all_xor & nse_pkg::MASK_E1);
    od[1] = ^(all_xor & nse_pkg::MASK_O1);
    ev[2] = ^(all_xor & nse_pkg::MASK_E2);
    od[2] = ^(all_xor & nse_pkg::MASK_O2);
    for (int j = 0; j < nse_pkg::NUM_PAIRS; j++) begin
      ev[3+j] = ^col_next[2*j];
      od[3+j] = ^col_next[2*j+1];
    end
    code_value = {ev[7:0], 4'h0, ev[11:8], od[7:0], 4'h0, od[11:8]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      held_code  <= '0;
      for (int k = 0; k < nse_pkg::NUM_COLS; k++) begin
        col[k] <= '0;
      end
    end else if (en) begin
      if (code_done) begin
        byte_count <= '0;
        held_code  <= code_value;
        for (int k = 0; k < nse_pkg::NUM_COLS; k++) begin
          col[k] <= '0;
        end
      end else begin
        byte_count <= byte_count + 1'b1;
        for (int k = 0; k < nse_pkg::NUM_COLS; k++) begin
          col[k] <= col_next[k];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/nse_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nse_check
// Syndrome classifier and sticky page verdict flags.
// ----------------------------------------------------------------------------
module nse_check (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic [31:0]  stored_ecc,
  input  wire logic         last_sector,
  input  wire logic [31:0]  held_code,
  output nse_pkg::chk_res_t res
);

  logic                        any_corrected;
  logic                        any_uncorrectable;
  logic                        any_corrected_next;
  logic                        any_uncorrectable_next;
  logic [31:0]                 syn;
  logic [nse_pkg::PAR_W-1:0]   ev;
  logic [nse_pkg::PAR_W-1:0]   od;
  logic                        one_bit;

  always_comb begin
    syn     = stored_ecc ^ held_code;
    ev      = {syn[19:16], syn[31:24]};
    od      = {syn[3:0], syn[15:8]};
    one_bit = ((syn & (syn - 32'd1)) == 32'd0);

    res.sector_status = nse_pkg::SECTOR_CLEAN;
    res.fix_byte      = '0;
    res.fix_bit       = '0;
    priority if (syn == 32'd0 || stored_ecc == nse_pkg::ERASED) begin
      res.sector_status = nse_pkg::SECTOR_CLEAN;
    end else if (one_bit) begin
      res.sector_status = nse_pkg::SECTOR_ECC;
    end else if ((ev ^ od) == nse_pkg::ALL_PAR) begin
      res.sector_status = nse_pkg::SECTOR_FIX;
      res.fix_byte      = od[11:3];
      res.fix_bit       = od[2:0];
    end else begin
      res.sector_status = nse_pkg::SECTOR_UNCOR;
    end

    any_corrected_next = any_corrected ||
                         res.sector_status == nse_pkg::SECTOR_ECC ||
                         res.sector_status == nse_pkg::SECTOR_FIX;
    any_uncorrectable_next = any_uncorrectable ||
                             res.sector_status == nse_pkg::SECTOR_UNCOR;

    res.page_status = nse_pkg::PAGE_CLEAN;
    if (last_sector) begin
      priority if (any_uncorrectable_next) begin
        res.page_status = nse_pkg::PAGE_UNCOR;
      end else if (any_corrected_next) begin
        res.page_status = nse_pkg::PAGE_CORRECTED;
      end else begin
        res.page_status = nse_pkg::PAGE_CLEAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_corrected     <= 1'b0;
      any_uncorrectable <= 1'b0;
    end else if (en) begin
      if (last_sector) begin
        any_corrected     <= 1'b0;
        any_uncorrectable <= 1'b0;
      end else begin
        any_corrected     <= any_corrected_next;
        any_uncorrectable <= any_uncorrectable_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/nand_sector_ecc_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nand_sector_ecc_engine_top
// Hamming ECC over 512-byte NAND sectors: code generation and checking.
// Each beat is held in the input register, and its result then in the output register.
// Throughput: one beat per cycle; the input register and the output register
// are each one stage, and a stalled output holds only items that give results.
// Reset clears the column bytes, the byte count, the held code, the page
// flags and both valid bits.
// ----------------------------------------------------------------------------
module nand_sector_ecc_engine_top (
  input  wire logic     clk,
  input  wire logic     rst,
  nse_item_if.sink      item,
  nse_result_if.source  result
);

  logic        s1_valid;
  logic        s1_cmd;
  logic [7:0]  s1_byte;
  logic [31:0] s1_stored;
  logic        s1_last;
  logic        s1_has_result;
  logic        s1_go;
  logic        out_free;

  logic        code_done;
  logic [31:0] code_value;
  logic [31:0] held_code;
  nse_pkg::chk_res_t chk;

  assign s1_has_result = (s1_cmd == nse_pkg::CMD_CHECK) || code_done;
  assign out_free      = !result.valid || result.ready;
  assign s1_go         = s1_valid && (!s1_has_result || out_free);
  assign item.ready    = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_cmd    <= item.cmd;
      s1_byte   <= item.data_byte;
      s1_stored <= item.stored_ecc;
      s1_last   <= item.last_sector;
    end
  end

  nse_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_go && s1_cmd == nse_pkg::CMD_DATA),
    .data_byte  (s1_byte),
    .code_done  (code_done),
    .code_value (code_value),
    .held_code  (held_code)
  );

  nse_check u_check (
    .clk         (clk),
    .rst         (rst),
    .en          (s1_go && s1_cmd == nse_pkg::CMD_CHECK),
    .stored_ecc  (s1_stored),
    .last_sector (s1_last),
    .held_code   (held_code),
    .res         (chk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_go && s1_has_result) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_has_result) begin
      if (s1_cmd == nse_pkg::CMD_CHECK) begin
        result.result_kind   <= nse_pkg::KIND_CHECK;
        result.ecc_value     <= held_code;
        result.sector_status <= chk.sector_status;
        result.fix_byte      <= chk.fix_byte;
        result.fix_bit       <= chk.fix_bit;
        result.page_status   <= chk.page_status;
        result.page_done     <= s1_last;
      end else begin
        result.result_kind   <= nse_pkg::KIND_CODE;
        result.ecc_value     <= code_value;
        result.sector_status <= nse_pkg::SECTOR_CLEAN;
        result.fix_byte      <= '0;
        result.fix_bit       <= '0;
        result.page_status   <= nse_pkg::PAGE_CLEAN;
        result.page_done     <= 1'b0;
      end
    end
  end

  a_page_done_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.page_done |-> result.result_kind == nse_pkg::KIND_CHECK)
    else $error("page verdict on a code beat");

  a_fix_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.sector_status != nse_pkg::SECTOR_FIX
      |-> result.fix_byte == '0 && result.fix_bit == '0)
    else $error("fix position without a fixable data bit");

  a_code_beat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == nse_pkg::KIND_CODE
      |-> result.sector_status == nse_pkg::SECTOR_CLEAN &&
          result.page_status == nse_pkg::PAGE_CLEAN)
    else $error("status on a code beat");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_cmd) && $stable(s1_stored))
    else $error("input stage lost a stalled beat");

endmodule
`default_nettype wire
